// ===== rtl/core/sha1bsh_pkg.sv =====
package sha1bsh_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FINAL,
        S_PAD,
        S_OUT
    } t_state;

    // Padding phases
    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } t_pad_phase;

    typedef logic [31:0] t_word;

    // Channel payloads
    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam t_word INIT_H [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [5:0] LAST_POS     = 6'd63;
    localparam logic [5:0] PRE_LEN_POS  = 6'd55;
    localparam logic [2:0] LAST_LEN_IDX = 3'd7;
    localparam logic [2:0] LAST_WORD    = 3'd4;
    localparam logic [7:0] PAD_MARK     = 8'h80;

    // Round boolean function
    function automatic t_word f_round_fn(input logic [6:0] rnd, input t_word b,
                                         input t_word c, input t_word d);
        t_word f;
        if (rnd < 7'd20) begin
            f = d ^ (b & (c ^ d));
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (d & (b | c));
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    // Round constant
    function automatic t_word f_round_k(input logic [6:0] rnd);
        t_word k;
        if (rnd < 7'd20) begin
            k = K_0;
        end else if (rnd < 7'd40) begin
            k = K_1;
        end else if (rnd < 7'd60) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/sha1bsh_stream_if.sv =====
// Byte input channel
interface sha1bsh_in_if;
    logic                 valid;
    logic                 ready;
    sha1bsh_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Digest output channel
interface sha1bsh_out_if;
    logic                  valid;
    logic                  ready;
    sha1bsh_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sha1_byte_stream_hasher.sv =====
// SHA-1 hasher fed one message byte per transfer on i_msg.
// Each i_msg transfer carries message_byte (valid when byte_present is set)
// and end_of_message. A bare end marker (no byte) closes the message, so the
// empty message is hashed by one bare end transfer after reset or a digest.
// A byte that does not complete a 64-byte block leaves the intake open for
// the next byte. The 64th byte starts a compression: 80 rounds on the
// single shared round adder, one round per cycle, then a fold into the
// chaining words. On end of message the sequencer injects padding and the
// length, one byte per cycle, compressing as blocks fill (one or two
// blocks), then offers the five digest words on o_digest, word_index 0
// first, last_word on word 4. i_msg.ready is low while a block compresses
// after a block-filling byte, and from an end transfer until the fifth
// digest word transfers. A stall on o_digest holds the current word;
// nothing is lost. Synchronous reset (i_rst_n low) loads the initial
// chaining words and a zero byte count; the block buffer needs no clearing.
module sha1_byte_stream_hasher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sha1bsh_in_if.sink           i_msg,
    sha1bsh_out_if.source        o_digest
);

    sha1bsh_pkg::t_state     r_state, n_state;
    sha1bsh_pkg::t_pad_phase r_phase;
    sha1bsh_pkg::t_word      r_chain [5];
    sha1bsh_pkg::t_word      r_a, r_b, r_c, r_d, r_e;
    logic [60:0]             r_total;
    logic [63:0]             r_bit_len;
    logic [511:0]            r_blk;
    logic [6:0]              r_round;
    logic [2:0]              r_len_idx;
    logic [2:0]              r_idx;
    logic                    r_pad_on;
    logic                    r_pad_done;

    logic                    in_fire;
    logic                    out_fire;
    logic [5:0]              pos;
    logic                    take;
    logic [7:0]              take_val;
    logic                    blk_full;
    sha1bsh_pkg::t_word      w_cur;
    sha1bsh_pkg::t_word      w_mix;
    sha1bsh_pkg::t_word      w_new;
    sha1bsh_pkg::t_word      round_sum;

    assign in_fire  = i_msg.valid & i_msg.ready;
    assign out_fire = o_digest.valid & o_digest.ready;
    assign pos      = r_total[5:0];

    // Byte intake: either the accepted message byte or a padding byte
    always_comb begin
        take     = 1'b0;
        take_val = i_msg.payload.message_byte;
        if (r_state == sha1bsh_pkg::S_IDLE) begin
            take     = in_fire & i_msg.payload.byte_present;
            take_val = i_msg.payload.message_byte;
        end else if (r_state == sha1bsh_pkg::S_PAD) begin
            take = 1'b1;
            case (r_phase)
                sha1bsh_pkg::PH_MARK: take_val = sha1bsh_pkg::PAD_MARK;
                sha1bsh_pkg::PH_LEN:  take_val = r_bit_len[{3'd7 - r_len_idx, 3'b000} +: 8];
                default:              take_val = 8'h00;
            endcase
        end
    end

    assign blk_full = take && (pos == sha1bsh_pkg::LAST_POS);

    // Schedule window: word 0 is the oldest, in the top bits
    assign w_cur = r_blk[511:480];
    assign w_mix = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    assign w_new = {w_mix[30:0], w_mix[31]};

    // Shared round adder
    assign round_sum = {r_a[26:0], r_a[31:27]}
                     + sha1bsh_pkg::f_round_fn(r_round, r_b, r_c, r_d)
                     + r_e + sha1bsh_pkg::f_round_k(r_round) + w_cur;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sha1bsh_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (blk_full) begin
                        n_state = sha1bsh_pkg::S_ROUND;
                    end else if (i_msg.payload.end_of_message) begin
                        n_state = sha1bsh_pkg::S_PAD;
                    end
                end
            end
            sha1bsh_pkg::S_ROUND: begin
                if (r_round == sha1bsh_pkg::LAST_ROUND) begin
                    n_state = sha1bsh_pkg::S_FINAL;
                end
            end
            sha1bsh_pkg::S_FINAL: begin
                if (!r_pad_on) begin
                    n_state = sha1bsh_pkg::S_IDLE;
                end else if (r_pad_done) begin
                    n_state = sha1bsh_pkg::S_OUT;
                end else begin
                    n_state = sha1bsh_pkg::S_PAD;
                end
            end
            sha1bsh_pkg::S_PAD: begin
                if (blk_full) begin
                    n_state = sha1bsh_pkg::S_ROUND;
                end
            end
            sha1bsh_pkg::S_OUT: begin
                if (out_fire && (r_idx == sha1bsh_pkg::LAST_WORD)) begin
                    n_state = sha1bsh_pkg::S_IDLE;
                end
            end
            default: n_state = sha1bsh_pkg::S_IDLE;
        endcase
    end

    // Channel outputs
    always_comb begin
        i_msg.ready                  = (r_state == sha1bsh_pkg::S_IDLE);
        o_digest.valid               = (r_state == sha1bsh_pkg::S_OUT);
        o_digest.payload.digest_word = r_chain[r_idx];
        o_digest.payload.word_index  = r_idx;
        o_digest.payload.last_word   = (r_idx == sha1bsh_pkg::LAST_WORD);
    end

    // Control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha1bsh_pkg::S_IDLE;
            r_phase    <= sha1bsh_pkg::PH_MARK;
            r_total    <= '0;
            r_round    <= '0;
            r_len_idx  <= '0;
            r_idx      <= '0;
            r_pad_on   <= 1'b0;
            r_pad_done <= 1'b0;
            r_chain    <= sha1bsh_pkg::INIT_H;
        end else begin
            r_state <= n_state;

            if (take) begin
                r_total <= r_total + 61'd1;
            end

            // end of message arms the padding sequence
            if (r_state == sha1bsh_pkg::S_IDLE && in_fire &&
                i_msg.payload.end_of_message) begin
                r_pad_on   <= 1'b1;
                r_pad_done <= 1'b0;
                r_phase    <= sha1bsh_pkg::PH_MARK;
                r_len_idx  <= '0;
            end

            // padding phase steps
            if (r_state == sha1bsh_pkg::S_PAD) begin
                case (r_phase)
                    sha1bsh_pkg::PH_MARK: begin
                        r_phase <= (pos == sha1bsh_pkg::PRE_LEN_POS) ?
                                   sha1bsh_pkg::PH_LEN : sha1bsh_pkg::PH_ZERO;
                    end
                    sha1bsh_pkg::PH_ZERO: begin
                        if (pos == sha1bsh_pkg::PRE_LEN_POS) begin
                            r_phase <= sha1bsh_pkg::PH_LEN;
                        end
                    end
                    sha1bsh_pkg::PH_LEN: begin
                        r_len_idx <= r_len_idx + 3'd1;
                        if (r_len_idx == sha1bsh_pkg::LAST_LEN_IDX) begin
                            r_pad_done <= 1'b1;
                        end
                    end
                    default: r_phase <= sha1bsh_pkg::PH_MARK;
                endcase
            end

            // round counter
            if (blk_full) begin
                r_round <= '0;
            end else if (r_state == sha1bsh_pkg::S_ROUND) begin
                r_round <= r_round + 7'd1;
            end

            // fold working words into the chain
            if (r_state == sha1bsh_pkg::S_FINAL) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end

            // digest word transfers; restart after the last one
            if (r_state == sha1bsh_pkg::S_OUT && out_fire) begin
                if (r_idx == sha1bsh_pkg::LAST_WORD) begin
                    r_idx      <= '0;
                    r_chain    <= sha1bsh_pkg::INIT_H;
                    r_total    <= '0;
                    r_pad_on   <= 1'b0;
                    r_pad_done <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    // Datapath: block window, length, working words
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_blk <= {r_blk[503:0], take_val};
        end else if (r_state == sha1bsh_pkg::S_ROUND) begin
            r_blk <= {r_blk[479:0], w_new};
        end

        if (r_state == sha1bsh_pkg::S_IDLE && in_fire && i_msg.payload.end_of_message) begin
            r_bit_len <= {r_total + 61'(i_msg.payload.byte_present), 3'b000};
        end

        if (blk_full) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (r_state == sha1bsh_pkg::S_ROUND) begin
            r_a <= round_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

`ifndef NO_ASSERTIONS
    // intake and digest output never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_msg.ready && o_digest.valid))
        else $error("intake open while digest pending");

    // the last round always hands over to the chain update
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1bsh_pkg::S_ROUND && r_round == sha1bsh_pkg::LAST_ROUND)
        |=> r_state == sha1bsh_pkg::S_FINAL)
        else $error("round sequence did not end in chain update");

    // digest output starts only on a block boundary after full padding
    a_out_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1bsh_pkg::S_FINAL && r_pad_on && r_pad_done)
        |=> (r_state == sha1bsh_pkg::S_OUT && r_total[5:0] == 6'd0))
        else $error("digest offered off a block boundary");

    // last digest word restarts the message
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_digest.payload.last_word)
        |=> (r_state == sha1bsh_pkg::S_IDLE && r_total == 61'd0 && !r_pad_on))
        else $error("no restart after last digest word");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    typedef sha1bsh_pkg::t_in_item  t_in_item;
    typedef sha1bsh_pkg::t_out_item t_out_item;

    // Idle profile, stepped through as the stimulus drains
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int          STIM_ITEMS   = 300;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 500;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;
    localparam logic [5:0]  LEN_FIELD_AT = 6'd56;
    localparam logic [2:0]  FINAL_WORD   = 3'd4;

    localparam logic [31:0] ROUND_K0 = 32'h5A827999;
    localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;
    localparam logic [31:0] IV_0     = 32'h67452301;
    localparam logic [31:0] IV_1     = 32'hEFCDAB89;
    localparam logic [31:0] IV_2     = 32'h98BADCFE;
    localparam logic [31:0] IV_3     = 32'h10325476;
    localparam logic [31:0] IV_4     = 32'hC3D2E1F0;

    logic clk = 1'b0;
    logic rst_n;

    sha1bsh_in_if  msg_if ();
    sha1bsh_out_if dig_if ();

    sha1_byte_stream_hasher dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_msg    (msg_if),
        .o_digest (dig_if)
    );

    always #6 clk = ~clk;

    // Hash state mirrored by the testbench
    logic [31:0] chain_h [5];
    logic [7:0]  block_buf [64];
    logic [60:0] byte_count;

    t_in_item  msg_items [$];
    t_out_item digest_expect [$];

    int total_items   = 0;
    int n_stim        = 0;
    int n_accepted    = 0;
    int n_messages    = 0;
    int n_spill       = 0;
    int n_checked     = 0;
    int n_errors      = 0;
    int n_cycles      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic load_iv();
        chain_h[0] = IV_0;
        chain_h[1] = IV_1;
        chain_h[2] = IV_2;
        chain_h[3] = IV_3;
        chain_h[4] = IV_4;
        byte_count = '0;
    endtask

    // 80-round compression of the full block buffer
    task automatic compress_block_buf();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++) begin
            sched[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
        end
        for (int r = 16; r < 80; r++) begin
            sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = d ^ (b & (c ^ d));
                k = ROUND_K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = ROUND_K1;
            end else if (r < 60) begin
                f = (b & c) | (d & (b | c));
                k = ROUND_K2;
            end else begin
                f = b ^ c ^ d;
                k = ROUND_K3;
            end
            t = rotl(a, 5) + f + e + k + sched[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    task automatic absorb_byte(input logic [7:0] v);
        logic [5:0] pos;
        pos = byte_count[5:0];
        block_buf[pos] = v;
        byte_count = byte_count + 1'b1;
        if (pos == 6'd63) begin
            compress_block_buf();
        end
    endtask

    // Expected digest words for one accepted input transfer
    task automatic predict_digest(input t_in_item it);
        logic [63:0] bit_len;
        t_out_item   word;
        if (it.byte_present) begin
            absorb_byte(it.message_byte);
        end
        if (it.end_of_message) begin
            bit_len = {byte_count, 3'b000};
            if (byte_count[5:0] >= LEN_FIELD_AT) begin
                n_spill++;
            end
            absorb_byte(PAD_BYTE);
            while (byte_count[5:0] != LEN_FIELD_AT) begin
                absorb_byte(8'h00);
            end
            for (int i = 0; i < 8; i++) begin
                absorb_byte(bit_len[8*(7-i) +: 8]);
            end
            for (int i = 0; i < 5; i++) begin
                word.digest_word = chain_h[i];
                word.word_index  = 3'(i);
                word.last_word   = (3'(i) == FINAL_WORD);
                digest_expect.push_back(word);
            end
            n_messages++;
            load_iv();
        end
    endtask

    function automatic t_idle_mode idle_mode();
        int m;
        m = (total_items == 0) ? 0 : (n_accepted * 4) / total_items;
        if (m > 3) begin
            m = 3;
        end
        return t_idle_mode'(m);
    endfunction

    function automatic bit sender_idles();
        case (idle_mode())
            IDLE_SENDER: return $urandom_range(0, 99) < 84;
            IDLE_BOTH:   return $urandom_range(0, 99) < 32;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode())
            IDLE_RECEIVER: return $urandom_range(0, 99) < 84;
            IDLE_BOTH:     return $urandom_range(0, 99) < 32;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic push_item(input logic [7:0] v, input bit present, input bit eom);
        t_in_item it;
        it.message_byte   = v;
        it.byte_present   = present;
        it.end_of_message = eom;
        msg_items.push_back(it);
        if (present || eom) begin
            n_stim++;
        end
    endtask

    // One message of random bytes, closed either on its last byte or by a bare end
    task automatic add_message(input int len, input bit end_on_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                push_item(8'($urandom), 1'b0, 1'b0);
            end
            push_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!(end_on_byte && len > 0)) begin
            push_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item seen);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("%0t: %s: expected word %08h idx %0d last %0b, got %08h idx %0d last %0b",
                     $realtime, what, want.digest_word, want.word_index, want.last_word,
                     seen.digest_word, seen.word_index, seen.last_word);
        end
    endtask

    // Input driver: offers queued items, holds each until its transfer
    always @(posedge clk) begin : byte_driver
        if (!rst_n) begin
            msg_if.valid   <= 1'b0;
            msg_if.payload <= '0;
        end else begin
            if (msg_if.valid && msg_if.ready) begin
                predict_digest(msg_items.pop_front());
                n_accepted <= n_accepted + 1;
            end
            if (!msg_if.valid || msg_if.ready) begin
                if (msg_items.size() != 0 && !sender_idles()) begin
                    msg_if.valid   <= 1'b1;
                    msg_if.payload <= msg_items[0];
                end else begin
                    msg_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, early in the run so the input backs up
    always @(posedge clk) begin : holdoff_timer
        if (!rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && n_accepted >= total_items / 8) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Digest monitor: checks each transfer against the oldest expectation
    always @(posedge clk) begin : digest_monitor
        t_out_item seen;
        t_out_item want;
        if (!rst_n) begin
            dig_if.ready <= 1'b0;
        end else begin
            if (dig_if.valid && dig_if.ready) begin
                seen = dig_if.payload;
                if (digest_expect.size() == 0) begin
                    report_mismatch("unexpected digest word", seen, seen);
                end else begin
                    want = digest_expect.pop_front();
                    n_checked++;
                    if (seen.digest_word !== want.digest_word ||
                        seen.word_index !== want.word_index ||
                        seen.last_word !== want.last_word) begin
                        report_mismatch("digest mismatch", want, seen);
                    end
                end
            end
            dig_if.ready <= (hold_left == 0) && !receiver_stalls();
        end
    end

    // Watchdog
    always @(posedge clk) begin : watchdog
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d digest words outstanding",
                     n_cycles, digest_expect.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int pick;
        rst_n          = 1'b0;
        msg_if.valid   = 1'b0;
        msg_if.payload = '0;
        dig_if.ready   = 1'b0;
        load_iv();
        for (int i = 0; i < 64; i++) begin
            block_buf[i] = 8'h00;
        end

        // Directed: empty message, single extreme bytes, "abc", ignored items
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b0);
        push_item(8'hAA, 1'b0, 1'b1);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'hA5, 1'b1, 1'b1);
        push_item(8'h55, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b1);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h7F, 1'b1, 1'b1);

        // Random messages: mostly short, some around the padding boundary, a few multi-block
        while (n_stim < STIM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                add_message($urandom_range(0, 24), 1'($urandom_range(0, 1)));
            end else if (pick < 90) begin
                add_message($urandom_range(54, 65), 1'($urandom_range(0, 1)));
            end else begin
                add_message($urandom_range(110, 130), 1'($urandom_range(0, 1)));
            end
        end
        total_items = msg_items.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all items in, all digests out, then let the block settle
        while (msg_items.size() != 0 || msg_if.valid) begin
            @(negedge clk);
        end
        while (digest_expect.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Hashed %0d messages from %0d input transfers (%0d with padding spilling",
                 n_messages, total_items, n_spill);
        $display("into a second block); %0d digest words checked, %0d mismatches.",
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sha1_byte_stream_hasher.f =====
rtl/core/sha1bsh_pkg.sv
rtl/core/sha1bsh_stream_if.sv
rtl/core/sha1_byte_stream_hasher.sv
tb/testbench.sv
